// File: hw/rtl/sector_cache_tag_table_assert.svh
// Assertion macros for the checker of the sector cache tag table.
`ifndef SECTOR_CACHE_TAG_TABLE_ASSERT_SVH
`define SECTOR_CACHE_TAG_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SCTT_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("sector cache tag table: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define SCTT_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("sector cache tag table: next-cycle check failed");

`endif

// File: hw/rtl/sctt_pkg.sv
package sctt_pkg;

	localparam int CACHE_SLOTS  = 128;
	localparam int SECTOR_BYTES = 512;

	localparam int SLOT_W   = $clog2(CACHE_SLOTS);
	localparam int CNT_W    = $clog2(CACHE_SLOTS + 1);
	localparam int BYTES_W  = $clog2(SECTOR_BYTES + 1);
	localparam int PROD_W   = SLOT_W + BYTES_W;

	localparam int DRIVE_W  = 8;
	localparam int LBA_W    = 32;
	localparam int STAMP_W  = 16;
	localparam int SLOT_O_W = 7;
	localparam int OFF_W    = 16;

	typedef struct packed {
		logic [DRIVE_W-1:0] drive;
		logic [LBA_W-1:0]   sector;
		logic [STAMP_W-1:0] stamp;
	} tag_t;

	// controller to datapath
	typedef struct packed {
		logic start;     // latch request, restart the walk
		logic scan;      // issue one tag read, compare the previous one
		logic grab_hit;  // capture the matching slot as the result
		logic fill;      // tag the victim slot, advance the fill count
		logic emit;      // load the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hit;   // compared entry matches the request
		logic last;  // compared entry is the last valid one
		logic empty; // no slot holds a tag yet
	} status_t;

endpackage

// File: hw/rtl/sctt_ctrl.sv
module sctt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  sctt_pkg::status_t status,
	output sctt_pkg::cmd_t    cmd
);
	import sctt_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_FILL = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.start    = accept;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = status.empty ? ST_FILL : ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.hit) begin
					cmd.grab_hit = 1'b1;
					state_d      = ST_EMIT;
				end else if (status.last) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				cmd.fill = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				// hold until the output register is free
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: hw/rtl/sctt_dp.sv
module sctt_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [sctt_pkg::DRIVE_W-1:0]    drive,
	input  logic [sctt_pkg::LBA_W-1:0]      sector_lba,
	input  sctt_pkg::cmd_t                  cmd,
	output sctt_pkg::status_t               status,
	output logic                            hit,
	output logic [sctt_pkg::SLOT_O_W-1:0]   slot,
	output logic [sctt_pkg::OFF_W-1:0]      buffer_offset
);
	import sctt_pkg::*;

	tag_t               tag_mem [CACHE_SLOTS];
	tag_t               rd_s1;
	logic [SLOT_W-1:0]  idx_s1;
	logic               v_s1;

	logic [DRIVE_W-1:0] drive_q;
	logic [LBA_W-1:0]   lba_q;
	logic [SLOT_W-1:0]  ptr_q;
	logic [CNT_W-1:0]   n_valid_q;
	logic [STAMP_W-1:0] fill_count_q;
	logic [STAMP_W-1:0] min_stamp_q;
	logic [SLOT_W-1:0]  min_idx_q;
	logic               res_hit_q;
	logic [SLOT_W-1:0]  res_slot_q;
	logic               hit_q;
	logic [SLOT_O_W-1:0] slot_q;
	logic [OFF_W-1:0]   off_q;

	logic               full;
	logic [SLOT_W-1:0]  fill_slot;
	logic               match;
	logic [PROD_W-1:0]  offset_prod;

	// valid slots always form a prefix, so a count stands in for valid bits
	assign full      = (n_valid_q == CNT_W'(CACHE_SLOTS));
	assign fill_slot = full ? min_idx_q : n_valid_q[SLOT_W-1:0];
	assign match     = (rd_s1.drive == drive_q) && (rd_s1.sector == lba_q);

	assign status.hit   = v_s1 && match;
	assign status.last  = v_s1 && ((CNT_W'(idx_s1) + CNT_W'(1)) == n_valid_q);
	assign status.empty = (n_valid_q == '0);

	assign offset_prod = PROD_W'(res_slot_q) * PROD_W'(SECTOR_BYTES);

	assign hit           = hit_q;
	assign slot          = slot_q;
	assign buffer_offset = off_q;

	// tag memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.fill) begin
			tag_mem[fill_slot] <= '{drive: drive_q, sector: lba_q, stamp: fill_count_q};
		end
		if (cmd.scan) begin
			rd_s1  <= tag_mem[ptr_q];
			idx_s1 <= ptr_q;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			drive_q <= drive;
			lba_q   <= sector_lba;
		end
		// oldest stamp so far, lowest slot wins a tie
		if (cmd.scan && v_s1 && ((idx_s1 == '0) || (rd_s1.stamp < min_stamp_q))) begin
			min_stamp_q <= rd_s1.stamp;
			min_idx_q   <= idx_s1;
		end
		if (cmd.grab_hit) begin
			res_hit_q  <= 1'b1;
			res_slot_q <= idx_s1;
		end else if (cmd.fill) begin
			res_hit_q  <= 1'b0;
			res_slot_q <= fill_slot;
		end
		if (cmd.emit) begin
			hit_q  <= res_hit_q;
			slot_q <= SLOT_O_W'(res_slot_q);
			off_q  <= OFF_W'(offset_prod);
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q        <= '0;
			v_s1         <= 1'b0;
			n_valid_q    <= '0;
			fill_count_q <= '0;
		end else begin
			if (cmd.start) begin
				ptr_q <= '0;
				v_s1  <= 1'b0;
			end else if (cmd.scan) begin
				ptr_q <= ptr_q + SLOT_W'(1);
				v_s1  <= 1'b1;
			end
			if (cmd.fill) begin
				fill_count_q <= fill_count_q + STAMP_W'(1);
				if (!full) begin
					n_valid_q <= n_valid_q + CNT_W'(1);
				end
			end
		end
	end

endmodule

// File: hw/rtl/sector_cache_tag_table.sv
// Fully associative tag table for a disk sector cache of 128 slots. Each request item carries a
// drive number and a sector address; exactly one result item comes back per request. On a hit,
// hit is 1 and slot names the slot holding that drive and sector. On a miss, hit is 0 and the
// block fills the first empty slot or, once all are in use, the slot with the smallest fill
// stamp (plain unsigned compare, lowest slot on a tie), tagging it with the 16-bit fill count,
// which then advances and wraps. buffer_offset is slot times 512, kept to 16 bits. The tag
// memory has one read port and is walked one slot per cycle; the block takes one item at
// a time but accepts the next one while a finished result still waits in the output register.
// Reset needs no clearing pass: a count of filled slots marks which tags are valid.
module sector_cache_tag_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [sctt_pkg::DRIVE_W-1:0]  drive,
	input  logic [sctt_pkg::LBA_W-1:0]    sector_lba,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          hit,
	output logic [sctt_pkg::SLOT_O_W-1:0] slot,
	output logic [sctt_pkg::OFF_W-1:0]    buffer_offset
);
	import sctt_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequence the walk: accept, scan the tags, fill on a miss, emit
	sctt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// hold the tags, compare one per cycle, track the oldest stamp
	sctt_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.drive         (drive),
		.sector_lba    (sector_lba),
		.cmd           (cmd),
		.status        (status),
		.hit           (hit),
		.slot          (slot),
		.buffer_offset (buffer_offset)
	);

endmodule

// File: hw/rtl/sctt_checker.sv
`include "sector_cache_tag_table_assert.svh"

module sctt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [sctt_pkg::DRIVE_W-1:0]  drive,
	input logic [sctt_pkg::LBA_W-1:0]    sector_lba,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          hit,
	input logic [sctt_pkg::SLOT_O_W-1:0] slot,
	input logic [sctt_pkg::OFF_W-1:0]    buffer_offset
);
	import sctt_pkg::*;

	// a waiting request keeps its payload
	`SCTT_ASSERT_NEXT(a_in_hold, clk, arst_n, in_valid && !in_ready, $stable({drive, sector_lba}))

	// a stalled result keeps its slot and hit flag
	`SCTT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(slot) && $stable(hit))

	// an accepted item keeps the block busy on the next cycle
	`SCTT_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	// offset always agrees with the slot
	`SCTT_ASSERT_IMPLY(a_offset, clk, arst_n, out_valid, buffer_offset == OFF_W'(32'(slot) * SECTOR_BYTES))

	// a new result appears only as an item finishes its walk
	`SCTT_ASSERT_IMPLY(a_emit_from_busy, clk, arst_n, $rose(out_valid), $past(!in_ready))

endmodule

bind sector_cache_tag_table sctt_checker u_sctt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.drive         (drive),
	.sector_lba    (sector_lba),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.hit           (hit),
	.slot          (slot),
	.buffer_offset (buffer_offset)
);

// File: test/sector_cache_tag_table_checker.sv
`timescale 1ns / 100ps

module sector_cache_tag_table_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [sctt_pkg::DRIVE_W-1:0]  drive,
	input  logic [sctt_pkg::LBA_W-1:0]    sector_lba,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic                          hit,
	input  logic [sctt_pkg::SLOT_O_W-1:0] slot,
	input  logic [sctt_pkg::OFF_W-1:0]    buffer_offset,
	output int                            fail_count,
	output int                            pending
);
	import sctt_pkg::*;

	typedef struct packed {
		logic                hit;
		logic [SLOT_O_W-1:0] slot;
		logic [OFF_W-1:0]    offset;
	} lookup_reply_t;

	logic               tag_valid  [CACHE_SLOTS];
	logic [DRIVE_W-1:0] tag_drive  [CACHE_SLOTS];
	logic [LBA_W-1:0]   tag_sector [CACHE_SLOTS];
	logic [STAMP_W-1:0] tag_stamp  [CACHE_SLOTS];
	logic [STAMP_W-1:0] fill_stamp;

	lookup_reply_t expected_replies[$];

	// Search the tags; on a miss claim the first empty slot, else the oldest stamp.
	function automatic lookup_reply_t lookup_or_fill(input logic [DRIVE_W-1:0] d,
			input logic [LBA_W-1:0] lba);
		lookup_reply_t reply;
		int            pick;
		int            i;
		bit            found;
		pick  = 0;
		found = 1'b0;
		reply.hit = 1'b0;
		for (i = 0; i < CACHE_SLOTS && !found; i++) begin
			if (tag_valid[i] && tag_drive[i] == d && tag_sector[i] == lba) begin
				pick  = i;
				found = 1'b1;
				reply.hit = 1'b1;
			end
		end
		if (!found) begin
			for (i = 0; i < CACHE_SLOTS && !found; i++) begin
				if (!tag_valid[i]) begin
					pick  = i;
					found = 1'b1;
				end else if (tag_stamp[i] < tag_stamp[pick]) begin
					pick = i;
				end
			end
			tag_valid[pick]  = 1'b1;
			tag_drive[pick]  = d;
			tag_sector[pick] = lba;
			tag_stamp[pick]  = fill_stamp;
			fill_stamp       = fill_stamp + 1'b1;
		end
		reply.slot   = SLOT_O_W'(pick);
		reply.offset = OFF_W'(pick * SECTOR_BYTES);
		return reply;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lookup_reply_t want;
		if (!arst_n) begin
			for (int i = 0; i < CACHE_SLOTS; i++)
				tag_valid[i] = 1'b0;
			fill_stamp = '0;
			expected_replies.delete();
			pending = 0;
			fail_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_replies.size() == 0) begin
					$display("%0t: unexpected result hit=%0b slot=%0d offset=%0d",
						$time, hit, slot, buffer_offset);
					fail_count++;
				end else begin
					want = expected_replies.pop_front();
					if (hit !== want.hit) begin
						$display("%0t: hit mismatch, expected %0b, got %0b",
							$time, want.hit, hit);
						fail_count++;
					end
					if (slot !== want.slot) begin
						$display("%0t: slot mismatch, expected %0d, got %0d",
							$time, want.slot, slot);
						fail_count++;
					end
					if (buffer_offset !== want.offset) begin
						$display("%0t: buffer_offset mismatch, expected %0d, got %0d",
							$time, want.offset, buffer_offset);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				expected_replies.push_back(lookup_or_fill(drive, sector_lba));
			pending = expected_replies.size();
		end
	end

endmodule

// File: test/sector_cache_tag_table_tb.sv
`timescale 1ns / 100ps

module sector_cache_tag_table_tb;
	import sctt_pkg::*;

	localparam int RANDOM_ITEMS   = 1790;
	localparam int HISTORY_DEPTH  = 256;
	localparam int CYCLE_LIMIT    = 1000000;
	// Long enough for a full walk of the tag memory plus the output stage.
	localparam int DRAIN_CYCLES   = 150;
	// Hold off the receiver once, long enough to back the block up to its input.
	localparam int BACKUP_AT      = 300;
	localparam int BACKUP_CYCLES  = 600;

	typedef struct packed {
		logic [DRIVE_W-1:0] drive;
		logic [LBA_W-1:0]   lba;
	} sector_request_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [DRIVE_W-1:0]  drive;
	logic [LBA_W-1:0]    sector_lba;
	logic                out_valid;
	logic                out_ready;
	logic                hit;
	logic [SLOT_O_W-1:0] slot;
	logic [OFF_W-1:0]    buffer_offset;

	int fail_count;
	int pending;
	int sent_count;
	int cycle_count;

	// The last 256 requests issued, newest last; reuse them to produce hits.
	sector_request_t recent_requests[$];

	sector_cache_tag_table u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.drive         (drive),
		.sector_lba    (sector_lba),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.hit           (hit),
		.slot          (slot),
		.buffer_offset (buffer_offset)
	);

	sector_cache_tag_table_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.drive         (drive),
		.sector_lba    (sector_lba),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.hit           (hit),
		.slot          (slot),
		.buffer_offset (buffer_offset),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Draw the idle cycles before one item; calm phases run back to back.
	function automatic int draw_idle(input bit calm);
		if (calm)
			return 0;
		return $urandom_range(0, 3);
	endfunction

	// Offer one request item and hold it until the block takes it.
	// Enter and leave on a falling edge.
	task automatic issue_request(input logic [DRIVE_W-1:0] d, input logic [LBA_W-1:0] lba);
		int              gap;
		sector_request_t req;
		gap = draw_idle(((sent_count / 200) % 4) == 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		drive      <= d;
		sector_lba <= lba;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		sent_count++;
		req.drive = d;
		req.lba   = lba;
		recent_requests.push_back(req);
		if (recent_requests.size() > HISTORY_DEPTH)
			void'(recent_requests.pop_front());
	endtask

	// Mix repeats (hits), one-bit neighbors of recent keys (near misses),
	// a tight pool of small keys, and fully random keys that force fills
	// and, once every slot is in use, evictions of the oldest stamp.
	function automatic sector_request_t draw_request();
		sector_request_t req;
		int              pick;
		int              bit_pos;
		pick = $urandom_range(0, 99);
		if (recent_requests.size() == 0 || pick >= 65) begin
			req.drive = DRIVE_W'($urandom);
			req.lba   = $urandom;
		end else if (pick < 45) begin
			req = recent_requests[$urandom_range(0, recent_requests.size() - 1)];
		end else if (pick < 55) begin
			req     = recent_requests[$urandom_range(0, recent_requests.size() - 1)];
			bit_pos = $urandom_range(0, DRIVE_W + LBA_W - 1);
			req     = req ^ ((DRIVE_W + LBA_W)'(1) << bit_pos);
		end else begin
			case ($urandom_range(0, 3))
				0: req.drive = 8'h00;
				1: req.drive = 8'h80;
				2: req.drive = 8'h81;
				default: req.drive = 8'hFF;
			endcase
			req.lba = LBA_W'($urandom_range(0, 63));
		end
		return req;
	endfunction

	// Stimulus: reset, a directed opening, then random traffic and drain.
	initial begin
		sector_request_t req;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		drive      = '0;
		sector_lba = '0;
		sent_count = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Field extremes: fill, then hit the same key.
		issue_request(8'h00, 32'h0000_0000);
		issue_request(8'h00, 32'h0000_0000);
		issue_request(8'hFF, 32'hFFFF_FFFF);
		issue_request(8'hFF, 32'hFFFF_FFFF);
		// Same sector on another drive and same drive on another sector must miss.
		issue_request(8'hFF, 32'h0000_0000);
		issue_request(8'h00, 32'hFFFF_FFFF);
		issue_request(8'h80, 32'h8000_0000);
		issue_request(8'h7F, 32'h7FFF_FFFF);
		issue_request(8'h80, 32'h7FFF_FFFF);
		issue_request(8'h01, 32'h0000_0001);
		// Revisit earlier keys, including the very first slot, then miss by one bit.
		issue_request(8'h00, 32'h0000_0000);
		issue_request(8'hFF, 32'h0000_0000);
		issue_request(8'h80, 32'h8000_0000);
		issue_request(8'h00, 32'hFFFF_FFFE);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			req = draw_request();
			issue_request(req.drive, req.lba);
		end
		in_valid <= 1'b0;

		// Drain: wait for every result, then watch for strays.
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Receiver: stall a random few cycles before each result item, calm
	// stretches aside, and once hold off long enough to back the block up.
	initial begin
		int stall;
		int taken;
		out_ready = 1'b0;
		taken = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (taken == BACKUP_AT)
				stall = BACKUP_CYCLES;
			else
				stall = draw_idle(((taken / 200) % 4) == 1);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			@(negedge clk);
			taken++;
		end
	end

	// Watchdog: abort a hung run.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

endmodule
